>>> hw/rtl/assert_macros.svh
// assertion macros used by the membership table top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock and disabled in reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock and disabled in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tlmt_pkg.sv
// shared types, constants and codes of the two-list membership table
package tlmt_pkg;

   // table geometry
   localparam int ENTRIES       = 1024;
   localparam int KEY_BITS      = 32;
   localparam int LIVE_BITS     = $clog2(ENTRIES + 1);
   localparam int COUNT_BITS    = 11;
   localparam int CNT_BITS      = (LIVE_BITS > COUNT_BITS) ? LIVE_BITS : COUNT_BITS;

   // match reduction tree
   localparam int TREE_LEAF     = 32;
   localparam int TREE_GROUPS   = (ENTRIES + TREE_LEAF - 1) / TREE_LEAF;

   // stream payload layout
   localparam int REQ_DATA_BITS  = 32;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_FIELD_BITS = 2 + 1 + 3 * COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FULL_BIT   = 2;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [1:0]          group_type;
   typedef logic [1:0]          command_type;

   // commands
   localparam command_type CMD_INSERT_A  = 2'd0;
   localparam command_type CMD_INSERT_B  = 2'd1;
   localparam command_type CMD_RESTORE_A = 2'd2;
   localparam command_type CMD_CLEAR     = 2'd3;

   // entry groups
   localparam group_type GRP_EMPTY = 2'd0;
   localparam group_type GRP_A     = 2'd1;
   localparam group_type GRP_B     = 2'd2;
   localparam group_type GRP_BOTH  = 2'd3;

   // broadcast from control to every cell
   typedef struct packed {
      logic      insert;
      group_type list_bit;
      logic      restore;
      logic      clear;
      key_type   key;
   } cell_cmd_type;

   // content handed from one cell to the next
   typedef struct packed {
      key_type   key;
      group_type grp;
   } cell_data_type;

endpackage

>>> hw/rtl/two_list_membership_table.sv
// Restore and clear: the result is registered from the execute state once the output is free.
// Insert: cell compare, two tree levels and decision when the key hits or the table is full;
// a new key waits in the decision state until cell 0 is empty. Requests are taken only in idle.
// The wait is set by the cell chain, where entries move one cell a cycle towards the tail.
// Reset is synchronous: cell groups and counts clear, keys stay undefined.
module two_list_membership_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tlmt_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // [31:0] key
   input  logic [tlmt_pkg::REQ_USER_BITS-1:0]    req_tuser,  // [1:0] command
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] membership, [2] table_full, [13:3] count_a, [24:14] count_b,
   // [35:25] count_both, [39:36] zero
   output logic [tlmt_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import tlmt_pkg::*;

`include "assert_macros.svh"

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_TREE1  = 3'd2;
   localparam logic [2:0] ST_TREE2  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;

   localparam logic [CNT_BITS-1:0]  CNT_ONE   = CNT_BITS'(1);
   localparam logic [LIVE_BITS-1:0] LIVE_ONE  = LIVE_BITS'(1);
   localparam logic [LIVE_BITS-1:0] LIVE_FULL = LIVE_BITS'(ENTRIES);

   logic [2:0]               state_ff, state_in;
   command_type              cmd_ff, cmd_in;
   key_type                  key_ff, key_in;
   group_type                found_ff, found_in;
   logic [CNT_BITS-1:0]      a_ff, a_in;
   logic [CNT_BITS-1:0]      b_ff, b_in;
   logic [CNT_BITS-1:0]      both_ff, both_in;
   logic [LIVE_BITS-1:0]     live_ff, live_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                     out_free;
   logic                     is_insert;
   group_type                list_bit;
   logic                     inject;
   logic                     finish;
   group_type                memb;
   logic                     full_flag;
   group_type                tree_grp;
   cell_cmd_type             cell_cmd;
   cell_data_type            inject_data;
   logic [ENTRIES-1:0]       cell_live;
   cell_data_type            cell_out [ENTRIES];
   logic [ENTRIES-1:0][1:0]  cell_oldg;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_insert  = (cmd_ff == CMD_INSERT_A) || (cmd_ff == CMD_INSERT_B);
   assign list_bit   = (cmd_ff == CMD_INSERT_B) ? GRP_B : GRP_A;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // command broadcast to the cells
   always_comb begin
      cell_cmd.insert   = (state_ff == ST_EXEC) && is_insert;
      cell_cmd.list_bit = list_bit;
      cell_cmd.restore  = (state_ff == ST_EXEC) && (cmd_ff == CMD_RESTORE_A) && out_free;
      cell_cmd.clear    = (state_ff == ST_EXEC) && (cmd_ff == CMD_CLEAR) && out_free;
      cell_cmd.key      = key_ff;
   end

   assign inject_data = '{key: key_ff, grp: list_bit};

   // chain of cells, cell 0 at the head takes new keys
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic          below_live;
      cell_data_type below_data;
      logic          above_empty;
      logic          inject_here;

      if (i == 0) begin : g_head
         assign below_live  = 1'b0;
         assign below_data  = '0;
         assign inject_here = inject;
      end else begin : g_body
         assign below_live  = cell_live[i-1];
         assign below_data  = cell_out[i-1];
         assign inject_here = 1'b0;
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign above_empty = 1'b0;
      end else begin : g_mid
         assign above_empty = !cell_live[i+1];
      end

      tlmt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .inject      (inject_here),
         .inject_data (inject_data),
         .below_live  (below_live),
         .below_data  (below_data),
         .above_empty (above_empty),
         .live        (cell_live[i]),
         .out_data    (cell_out[i]),
         .old_grp     (cell_oldg[i])
      );
   end

   // or of the matched cell's former group
   tlmt_or_tree u_tree (
      .clock    (clock),
      .leaf_grp (cell_oldg),
      .any_grp  (tree_grp)
   );

   // sequencer, counters and result register
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      both_in      = both_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      inject       = 1'b0;
      finish       = 1'b0;
      memb         = GRP_EMPTY;
      full_flag    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               key_in   = key_type'(req_tdata);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_insert) begin
               state_in = ST_TREE1;
            end else if (out_free) begin
               if (cmd_ff == CMD_RESTORE_A) begin
                  a_in    = a_ff + both_ff;
                  b_in    = '0;
                  both_in = '0;
                  live_in = live_ff - LIVE_BITS'(b_ff);
               end else begin
                  a_in    = '0;
                  b_in    = '0;
                  both_in = '0;
                  live_in = '0;
               end
               finish = 1'b1;
            end
         end
         ST_TREE1: begin
            state_in = ST_TREE2;
         end
         ST_TREE2: begin
            found_in = tree_grp;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (found_ff != GRP_EMPTY) begin
                  // key present: join the other list if not yet in it
                  memb = found_ff | list_bit;
                  if (memb != found_ff) begin
                     both_in = both_ff + CNT_ONE;
                     if (found_ff == GRP_A) begin
                        a_in = a_ff - CNT_ONE;
                     end else begin
                        b_in = b_ff - CNT_ONE;
                     end
                  end
                  finish = 1'b1;
               end else if (live_ff == LIVE_FULL) begin
                  // no entry free: drop the key
                  full_flag = 1'b1;
                  finish    = 1'b1;
               end else if (!cell_live[0]) begin
                  // new key goes into the empty head cell
                  inject  = 1'b1;
                  memb    = list_bit;
                  live_in = live_ff + LIVE_ONE;
                  if (list_bit == GRP_A) begin
                     a_in = a_ff + CNT_ONE;
                  end else begin
                     b_in = b_ff + CNT_ONE;
                  end
                  finish = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_BITS'({COUNT_BITS'(both_in), COUNT_BITS'(b_in),
                                        COUNT_BITS'(a_in), full_flag, memb});
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_ff         <= '0;
         b_ff         <= '0;
         both_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         both_ff      <= both_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `ASSERT_NEXT(a_accept_starts_exec, req_tvalid && req_tready, state_ff == ST_EXEC,
                "accepted transaction did not start execution")
   `ASSERT_IMPLY(a_counts_match_live, 1'b1, a_ff + b_ff + both_ff == CNT_BITS'(live_ff),
                 "group counters disagree with live entry count")
   `ASSERT_NEXT(a_inject_fills_head, inject, cell_live[0],
                "new key did not land in the head cell")
   `ASSERT_IMPLY(a_full_no_membership, rsp_valid_ff && rsp_data_ff[RSP_FULL_BIT],
                 rsp_data_ff[1:0] == GRP_EMPTY, "dropped key reported with a membership")

endmodule

>>> hw/rtl/tlmt_cell.sv
// one table cell: holds a key and its group, matches and drifts towards the tail
module tlmt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tlmt_pkg::cell_cmd_type cmd,
   input  logic                   inject,
   input  tlmt_pkg::cell_data_type inject_data,
   input  logic                   below_live,
   input  tlmt_pkg::cell_data_type below_data,
   input  logic                   above_empty,
   output logic                   live,
   output tlmt_pkg::cell_data_type out_data,
   output tlmt_pkg::group_type    old_grp
);
   import tlmt_pkg::*;

   key_type   key_ff;
   key_type   key_in;
   group_type grp_ff;
   group_type grp_in;
   group_type grp_upd;
   group_type oldg_ff;
   group_type oldg_in;
   logic      hit;
   logic      take_below;
   logic      give_up;

   assign live = (grp_ff != GRP_EMPTY);

   // key match against the broadcast command
   assign hit = cmd.insert && live && (key_ff == cmd.key);

   // group after this cycle's command, wherever the entry ends up
   always_comb begin
      grp_upd = grp_ff;
      if (cmd.clear) begin
         grp_upd = GRP_EMPTY;
      end else if (cmd.restore) begin
         if (grp_ff == GRP_BOTH) begin
            grp_upd = GRP_A;
         end else if (grp_ff == GRP_B) begin
            grp_upd = GRP_EMPTY;
         end
      end else if (hit) begin
         grp_upd = grp_ff | cmd.list_bit;
      end
   end

   assign out_data = '{key: key_ff, grp: grp_upd};

   // drift: an entry moves one cell up into an empty neighbour
   assign take_below = !live && below_live;
   assign give_up    = live && above_empty;

   always_comb begin
      key_in = key_ff;
      grp_in = grp_upd;
      if (inject) begin
         key_in = inject_data.key;
         grp_in = inject_data.grp;
      end else if (take_below) begin
         key_in = below_data.key;
         grp_in = below_data.grp;
      end else if (give_up) begin
         grp_in = GRP_EMPTY;
      end
   end

   // group before the update, reported for the match tree
   assign oldg_in = hit ? grp_ff : GRP_EMPTY;
   assign old_grp = oldg_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff  <= GRP_EMPTY;
         oldg_ff <= GRP_EMPTY;
      end else begin
         grp_ff  <= grp_in;
         oldg_ff <= oldg_in;
      end
   end

endmodule

>>> hw/rtl/tlmt_or_tree.sv
// match reduction: registered first level over groups of cells, then a final or
module tlmt_or_tree (
   input  logic                                 clock,
   input  logic [tlmt_pkg::ENTRIES-1:0][1:0]    leaf_grp,
   output tlmt_pkg::group_type                  any_grp
);
   import tlmt_pkg::*;

   group_type [TREE_GROUPS-1:0] lvl1_ff;
   group_type [TREE_GROUPS-1:0] lvl1_in;

   // first level: or within each group of leaves
   always_comb begin
      for (int g = 0; g < TREE_GROUPS; g++) begin
         lvl1_in[g] = GRP_EMPTY;
         for (int i = 0; i < TREE_LEAF; i++) begin
            if (g * TREE_LEAF + i < ENTRIES) begin
               lvl1_in[g] = lvl1_in[g] | leaf_grp[g * TREE_LEAF + i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl1_ff <= lvl1_in;
   end

   // second level: or of the group results
   always_comb begin
      any_grp = GRP_EMPTY;
      for (int g = 0; g < TREE_GROUPS; g++) begin
         any_grp = any_grp | lvl1_ff[g];
      end
   end

endmodule
